[sv/gbw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian blur window filter package
// Shared widths, register codes, Gaussian base table and pipeline types.
// ----------------------------------------------------------------------------
package gbw_pkg;

  // Fixed field widths of the channels.
  localparam int PIX_W       = 32;
  localparam int SAMPLE_W    = 8;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_COORD_W = 10;

  // Frame dimension after reset, before any clamping to the maximum.
  localparam int DIM_RESET = 1024;

  // Low byte of every result word and the saturation limit of the blur.
  localparam logic [SAMPLE_W-1:0] ALPHA_BYTE = 8'hFF;
  localparam logic [SAMPLE_W-1:0] SAT_MAX    = 8'd255;

  // exp(-k*k/2) for k = 0..4 as unsigned Q1.20 values.
  localparam longint unsigned GAUSS_Q20 [5] = '{
    64'd1048576, 64'd635993, 64'd141909, 64'd11649, 64'd352
  };

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_t;

  // Result tag that travels down the pipeline next to the pixel data.
  typedef struct packed {
    logic [OUT_COORD_W-1:0] column;
    logic [OUT_COORD_W-1:0] row;
    logic                   frame_end;
  } res_meta_t;

endpackage

[sv/gbw_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel input channel
// Valid/ready channel that carries one packed 32-bit pixel word.
// ----------------------------------------------------------------------------
interface gbw_pix_if
  import gbw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink (input valid, input pixel_word, output ready);
endinterface

[sv/gbw_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blurred result channel
// Valid/ready channel that carries a blurred pixel and its coordinate.
// ----------------------------------------------------------------------------
interface gbw_res_if
  import gbw_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [PIX_W-1:0]       blurred_pixel;
  logic [OUT_COORD_W-1:0] out_column;
  logic [OUT_COORD_W-1:0] out_row;
  logic                   frame_end;

  modport source (output valid, output blurred_pixel, output out_column,
                  output out_row, output frame_end, input ready);
  modport sink (input valid, input blurred_pixel, input out_column,
                input out_row, input frame_end, output ready);
endinterface

[sv/gbw_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface gbw_cfg_if
  import gbw_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
endinterface

[sv/gbw_line_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line buffer memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbw_line_buf #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds while the read is not enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/gbw_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window column cell
// Holds one column of the blur window, passes it to its left neighbor on
// each shift and forms the weighted sum of its own column.
// ----------------------------------------------------------------------------
module gbw_cell
  import gbw_pkg::*;
#(
  parameter int RADIUS      = 2,
  parameter int WEIGHT_BITS = 16,
  parameter int COL_IDX     = 0,
  parameter int SPAN        = 2 * RADIUS + 1,
  parameter int PART_W      = SAMPLE_W + WEIGHT_BITS + 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic                     calc_en,
  input  logic [SPAN*SAMPLE_W-1:0] col_in,
  output logic [SPAN*SAMPLE_W-1:0] col_out,
  output logic [PART_W-1:0]        part_out
);

  // Normalizing sum of the one-dimensional kernel.
  localparam longint unsigned GSUM = GAUSS_Q20[0]
    + 2 * ((RADIUS >= 1 ? GAUSS_Q20[1] : 64'd0) + (RADIUS >= 2 ? GAUSS_Q20[2] : 64'd0)
         + (RADIUS >= 3 ? GAUSS_Q20[3] : 64'd0) + (RADIUS >= 4 ? GAUSS_Q20[4] : 64'd0));

  // One-dimensional weights in Q0.WEIGHT_BITS, rounded half up.
  localparam longint unsigned H0 = ((GAUSS_Q20[0] << WEIGHT_BITS) + GSUM / 2) / GSUM;
  localparam longint unsigned H1 = ((GAUSS_Q20[1] << WEIGHT_BITS) + GSUM / 2) / GSUM;
  localparam longint unsigned H2 = ((GAUSS_Q20[2] << WEIGHT_BITS) + GSUM / 2) / GSUM;
  localparam longint unsigned H3 = ((GAUSS_Q20[3] << WEIGHT_BITS) + GSUM / 2) / GSUM;
  localparam longint unsigned H4 = ((GAUSS_Q20[4] << WEIGHT_BITS) + GSUM / 2) / GSUM;

  localparam int AC = (COL_IDX > RADIUS) ? COL_IDX - RADIUS : RADIUS - COL_IDX;

  function automatic longint unsigned h_of(input int k);
    longint unsigned h;
    case (k)
      0:       h = H0;
      1:       h = H1;
      2:       h = H2;
      3:       h = H3;
      default: h = H4;
    endcase
    return h;
  endfunction

  // Two-dimensional weight: product of the row and column weights, rounded.
  function automatic longint unsigned tap_weight(input int ar, input int ac);
    longint unsigned p;
    p = h_of(ar) * h_of(ac);
    return (p + (64'd1 << (WEIGHT_BITS - 1))) >> WEIGHT_BITS;
  endfunction

  logic [SPAN*SAMPLE_W-1:0] col_r;
  logic [PART_W-1:0]        part_r;
  logic [PART_W-1:0]        prod [SPAN];
  logic [PART_W-1:0]        part_nxt;

  // Constant-weight product for each row of the column.
  for (genvar r = 0; r < SPAN; r++) begin : g_tap
    localparam int              AR = (r > RADIUS) ? r - RADIUS : RADIUS - r;
    localparam longint unsigned WT = tap_weight(AR, AC);
    assign prod[r] = PART_W'(col_r[r*SAMPLE_W +: SAMPLE_W]) * PART_W'(WT);
  end

  // Column sum of the weighted samples.
  always_comb begin
    part_nxt = '0;
    for (int r = 0; r < SPAN; r++) begin
      part_nxt = part_nxt + prod[r];
    end
  end

  // Column storage; the window starts out zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  // Registered partial sum.
  always_ff @(posedge clk) begin
    if (calc_en) begin
      part_r <= part_nxt;
    end
  end

  assign col_out  = col_r;
  assign part_out = part_r;

endmodule

[sv/gaussian_blur_window_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian blur window filter
// Streaming (2*RADIUS+1)-square Gaussian blur (sigma 1) over byte 1 of each
// pixel word, with line buffers and a chain of window column cells.
//
//   Channel  Dir  Payload                                       Transfer when
//   in_pix   in   pixel_word                                    valid & ready
//   out_pix  out  blurred_pixel, out_column, out_row, frame_end valid & ready
//   cfg_wr   in   addr (0 width, 1 height), wdata               valid & ready
//
// One pixel is taken per clock unless the output stalls; each result is held
// in the output register. The rate is set by the single line-buffer read and
// write per pixel. Reset clears control state and the window; the line buffer
// is not cleared, since rows read before they are written give no result.
// A stalled output register stops the whole pipeline and drops in_pix.ready.
// A width or height write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module gaussian_blur_window_filter
  import gbw_pkg::*;
#(
  parameter int RADIUS      = 2,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  gbw_pix_if.sink    in_pix,
  gbw_res_if.source  out_pix,
  gbw_cfg_if.sink    cfg_wr
);

  localparam int SPAN    = 2 * RADIUS + 1;
  localparam int LINES   = 2 * RADIUS;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int LB_W    = LINES * SAMPLE_W;
  localparam int PART_W  = SAMPLE_W + WEIGHT_BITS + 4;
  localparam int ACC_W   = PART_W + 4;
  localparam int Q_W     = ACC_W - WEIGHT_BITS;
  localparam int RST_COL = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH - 1 : DIM_RESET - 1;
  localparam int RST_ROW = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT - 1 : DIM_RESET - 1;

  // Clamp a programmed dimension into the legal range.
  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned d;
    d = 32'(v);
    if (d < SPAN) begin
      d = SPAN;
    end else if (d > maxv) begin
      d = maxv;
    end
    return d;
  endfunction

  // Pipeline control.
  logic en;
  logic in_acc;

  // Frame position and limits.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] last_col_r, last_col_nxt;
  logic [ROW_W-1:0] last_row_r, last_row_nxt;

  // Stage 1: pixel and position while the line buffer is read.
  logic                s1_valid_r;
  logic                s1_prod_r;
  logic                s1_fe_r;
  logic [SAMPLE_W-1:0] s1_pix_r;
  logic [COL_W-1:0]    s1_col_r;
  res_meta_t           s1_meta_r;
  logic [COL_W-1:0]    oc_full;
  logic [ROW_W-1:0]    or_full;

  // Later stages.
  logic      s2_valid_r, s3_valid_r, out_valid_r;
  res_meta_t s2_meta_r, s3_meta_r, out_meta_r;
  logic [SAMPLE_W-1:0] out_byte_r;

  // Line buffer and window signals.
  logic [LB_W-1:0]          lb_rd_data;
  logic [SPAN*SAMPLE_W-1:0] new_col;
  logic [SPAN*SAMPLE_W-1:0] cols  [SPAN];
  logic [PART_W-1:0]        parts [SPAN];
  logic [ACC_W-1:0]         acc;
  logic [Q_W-1:0]           acc_q;
  logic [SAMPLE_W-1:0]      out_byte_nxt;

  assign en            = !out_valid_r || out_pix.ready;
  assign in_pix.ready  = en;
  assign in_acc        = in_pix.valid && en;
  assign cfg_wr.ready  = 1'b1;

  // Next frame position and programmed limits.
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    last_col_nxt = last_col_r;
    last_row_nxt = last_row_r;
    if (cfg_wr.valid) begin
      case (cfg_reg_t'(cfg_wr.addr))
        REG_WIDTH: begin
          last_col_nxt = COL_W'(clamp_dim(cfg_wr.wdata, MAX_WIDTH) - 1);
          col_nxt      = '0;
          row_nxt      = '0;
        end
        REG_HEIGHT: begin
          last_row_nxt = ROW_W'(clamp_dim(cfg_wr.wdata, MAX_HEIGHT) - 1);
          col_nxt      = '0;
          row_nxt      = '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (col_r == last_col_r) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      last_col_r <= COL_W'(RST_COL);
      last_row_r <= ROW_W'(RST_ROW);
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      last_col_r <= last_col_nxt;
      last_row_r <= last_row_nxt;
    end
  end

  // Coordinates in the frame shrunk by the border.
  assign oc_full = col_r - COL_W'(LINES);
  assign or_full = row_r - ROW_W'(LINES);

  // Stage 1 registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r            <= in_pix.pixel_word[15:8];
      s1_col_r            <= col_r;
      s1_prod_r           <= (row_r >= ROW_W'(LINES)) && (col_r >= COL_W'(LINES));
      s1_fe_r             <= (row_r == last_row_r) && (col_r == last_col_r);
      s1_meta_r.column    <= OUT_COORD_W'(oc_full);
      s1_meta_r.row       <= OUT_COORD_W'(or_full);
      s1_meta_r.frame_end <= (row_r == last_row_r) && (col_r == last_col_r);
    end
  end

  // Line buffer: each word holds one column of the last LINES rows.
  gbw_line_buf #(
    .DATA_W (LB_W),
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (lb_rd_data),
    .wr_en   (en && s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data ({s1_pix_r, lb_rd_data[LB_W-1:SAMPLE_W]})
  );

  // Newest window column: stored rows on top, the incoming sample at the bottom.
  assign new_col = {s1_pix_r, lb_rd_data};

  // Chain of column cells; data moves one cell to the left per pixel.
  for (genvar c = 0; c < SPAN; c++) begin : g_cell
    logic [SPAN*SAMPLE_W-1:0] cell_in;
    if (c == SPAN - 1) begin : g_last
      assign cell_in = new_col;
    end else begin : g_mid
      assign cell_in = cols[c+1];
    end
    gbw_cell #(
      .RADIUS      (RADIUS),
      .WEIGHT_BITS (WEIGHT_BITS),
      .COL_IDX     (c),
      .SPAN        (SPAN),
      .PART_W      (PART_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (en && s1_valid_r),
      .calc_en  (en),
      .col_in   (cell_in),
      .col_out  (cols[c]),
      .part_out (parts[c])
    );
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r  <= s1_valid_r && s1_prod_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Sum of the column partials, scaled and saturated.
  always_comb begin
    acc = '0;
    for (int c = 0; c < SPAN; c++) begin
      acc = acc + ACC_W'(parts[c]);
    end
    acc_q        = acc[ACC_W-1:WEIGHT_BITS];
    out_byte_nxt = (acc_q > Q_W'(SAT_MAX)) ? SAT_MAX : acc_q[SAMPLE_W-1:0];
  end

  // Result tag and output register.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_meta_r  <= s1_meta_r;
      s3_meta_r  <= s2_meta_r;
      out_meta_r <= s3_meta_r;
      out_byte_r <= out_byte_nxt;
    end
  end

  assign out_pix.valid         = out_valid_r;
  assign out_pix.blurred_pixel = {out_byte_r, out_byte_r, out_byte_r, ALPHA_BYTE};
  assign out_pix.out_column    = out_meta_r.column;
  assign out_pix.out_row       = out_meta_r.row;
  assign out_pix.frame_end     = out_meta_r.frame_end;

  // The frame position never passes the programmed limits.
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= last_col_r) && (row_r <= last_row_r))
    else $error("frame position beyond programmed limits");

  // A result only appears when the sum stage held a valid item.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_valid_r))
    else $error("result raised without a valid sum stage");

  // The last pixel of a frame always lies inside the border and makes a result.
  a_end_produces: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fe_r) |-> s1_prod_r)
    else $error("frame end pixel would give no result");

endmodule

[bench/gaussian_blur_window_filter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian blur window filter testbench
// Streams pixel frames of many geometries through the filter and checks each
// blurred result, coordinate and frame-end flag against a local prediction
// of the line stores, the 5x5 window and the fixed-point Gaussian weights.
// A short directed table runs first; random frames with random idle cycles
// on both channels and two long output stalls follow.
// ----------------------------------------------------------------------------
module gaussian_blur_window_filter_test;
  import gbw_pkg::*;

  localparam int RADIUS       = 2;
  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int WEIGHT_BITS  = 16;
  localparam int SPAN         = 2 * RADIUS + 1;
  localparam int LINES        = 2 * RADIUS;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int LIMIT        = 1000000;

  // Register indexes that decode to nothing.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0]       pixel;
    logic [OUT_COORD_W-1:0] column;
    logic [OUT_COORD_W-1:0] row;
    logic                   frame_end;
  } blur_result_t;

  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [PIX_W-1:0]      data;
    logic [7:0]            count;
    logic                  pinned;
    blur_result_t          pin_result;
  } stim_row_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] width;
    logic [CFG_DATA_W-1:0] height;
    logic [15:0]           pixels;
    logic                  idle_on;
    logic                  hold;
    logic                  spare_write;
  } frame_phase_t;

  logic clk = 1'b0;
  logic rst_n;

  gbw_pix_if pix_if ();
  gbw_res_if res_if ();
  gbw_cfg_if cfg_if ();

  gaussian_blur_window_filter #(
    .RADIUS      (RADIUS),
    .MAX_WIDTH   (MAX_W),
    .MAX_HEIGHT  (MAX_H),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_if),
    .out_pix (res_if),
    .cfg_wr  (cfg_if)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted filter state.
  bit [SAMPLE_W-1:0]  line_mem [LINES][MAX_W];
  bit [SAMPLE_W-1:0]  window [SPAN][SPAN];
  longint unsigned    blur_taps [SPAN][SPAN];
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(DIM_RESET);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(DIM_RESET);

  blur_result_t pending_blurs [$];
  blur_result_t pinned_result;
  bit           pinned_valid;

  bit          idle_on;
  bit          hold_request;
  int unsigned mismatch_count;
  int unsigned pixel_count;
  int unsigned result_count;
  int unsigned frame_count;
  int unsigned cycle_count;
  int unsigned setting_count;
  logic [SAMPLE_W-1:0] smooth_level;

  // Build the 2-D tap weights from the 1-D normalized Gaussian.
  initial begin : tap_setup
    longint unsigned norm;
    longint unsigned axis_w [RADIUS+1];
    int unsigned dr;
    int unsigned dc;
    norm = GAUSS_Q20[0];
    for (int k = 1; k <= RADIUS; k++) norm += 2 * GAUSS_Q20[k];
    for (int k = 0; k <= RADIUS; k++)
      axis_w[k] = ((GAUSS_Q20[k] << WEIGHT_BITS) + norm / 2) / norm;
    for (int r = 0; r < SPAN; r++) begin
      for (int c = 0; c < SPAN; c++) begin
        dr = (r > RADIUS) ? r - RADIUS : RADIUS - r;
        dc = (c > RADIUS) ? c - RADIUS : RADIUS - c;
        blur_taps[r][c] = (axis_w[dr] * axis_w[dc] + (64'd1 << (WEIGHT_BITS - 1)))
                          >> WEIGHT_BITS;
      end
    end
  end

  function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned top);
    if (v < SPAN) return SPAN;
    if (v > top) return top;
    return 32'(v);
  endfunction

  // A write to a known register changes the geometry and restarts the frame.
  function automatic void apply_reg_write(input logic [CFG_ADDR_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_WIDTH) width_reg = val;
    else if (idx == REG_HEIGHT) height_reg = val;
    else return;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Shift one pixel into the line stores and window; report the blur, if any.
  function automatic bit predict_blur(input logic [PIX_W-1:0] word,
                                      output blur_result_t res);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    logic [SAMPLE_W-1:0] px_byte;
    longint unsigned acc;
    logic [SAMPLE_W-1:0] level;
    bit made;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    col = (col_pos < w) ? col_pos : 0;
    row = (row_pos < h) ? row_pos : 0;
    px_byte = word[15:8];
    made = 1'b0;
    res = '0;
    for (int r = 0; r < SPAN; r++) begin
      for (int c = 0; c < SPAN - 1; c++) window[r][c] = window[r][c+1];
      window[r][SPAN-1] = (r < LINES) ? line_mem[r][col] : px_byte;
    end
    for (int r = 0; r < LINES - 1; r++) line_mem[r][col] = line_mem[r+1][col];
    line_mem[LINES-1][col] = px_byte;

    // Interior pixels only: full window available.
    if (row >= LINES && col >= LINES) begin
      acc = 0;
      for (int r = 0; r < SPAN; r++)
        for (int c = 0; c < SPAN; c++)
          acc += longint'(window[r][c]) * blur_taps[r][c];
      acc = acc >> WEIGHT_BITS;
      level = (acc > SAT_MAX) ? SAT_MAX : acc[SAMPLE_W-1:0];
      res.pixel = {level, level, level, ALPHA_BYTE};
      res.column = OUT_COORD_W'(col - LINES);
      res.row = OUT_COORD_W'(row - LINES);
      res.frame_end = (row == h - 1) && (col == w - 1);
      made = 1'b1;
    end

    if (col + 1 >= w) begin
      col_pos = 0;
      row_pos = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
    return made;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // Track every transfer: register writes, pixels in, results out.
  always @(posedge clk) begin : transfer_monitor
    blur_result_t want;
    blur_result_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) apply_reg_write(cfg_if.addr, cfg_if.wdata);
      if (pix_if.valid && pix_if.ready) begin
        pixel_count++;
        if (predict_blur(pix_if.pixel_word, want)) begin
          if (pinned_valid) want = pinned_result;
          pending_blurs.push_back(want);
        end else if (pinned_valid) begin
          mismatch_count++;
          $display("%0t: expected %0h for this pixel, but no result is predicted",
                   $time, pinned_result.pixel);
        end
        pinned_valid = 1'b0;
      end
      if (res_if.valid && res_if.ready) begin
        got = '{res_if.blurred_pixel, res_if.out_column, res_if.out_row,
                res_if.frame_end};
        result_count++;
        if (got.frame_end) frame_count++;
        if (pending_blurs.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none actual %0h col %0d row %0d",
                   $time, got.pixel, got.column, got.row);
        end else begin
          want = pending_blurs.pop_front();
          check_field("blurred_pixel", want.pixel, got.pixel);
          check_field("out_column", 32'(want.column), 32'(got.column));
          check_field("out_row", 32'(want.row), 32'(got.row));
          check_field("frame_end", 32'(want.frame_end), 32'(got.frame_end));
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               pending_blurs.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result receiver: random stall bursts, plus one long hold on request.
  initial begin : result_sink
    int unsigned burst;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 17);
        res_if.ready <= 1'b0;
        repeat (burst - 1) @(negedge clk);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Mix of random words, extreme samples and smooth regions.
  function automatic logic [PIX_W-1:0] random_pixel();
    logic [PIX_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 5))
      2: w[15:8] = 8'hFF;
      3: w[15:8] = 8'h00;
      4: begin
        smooth_level = smooth_level + 8'($urandom_range(0, 6)) - 8'd3;
        w[15:8] = smooth_level;
      end
      5: w[15:8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return w;
  endfunction

  // Offer one pixel, after an optional idle gap, and wait for its transfer.
  task automatic send_pixel(input logic [PIX_W-1:0] word, input bit pin,
                            input blur_result_t pin_res);
    int unsigned gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel_word <= $urandom;
      repeat (gap) @(negedge clk);
    end
    if (pin) begin
      pinned_result = pin_res;
      pinned_valid = 1'b1;
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_word <= word;
    do @(posedge clk); while (!pix_if.ready);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop offering pixels and let every result and the pipeline drain.
  task automatic wait_idle();
    @(negedge clk);
    pix_if.valid <= 1'b0;
    while (pending_blurs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  stim_row_t    directed_rows [9];
  frame_phase_t phases [8];

  initial begin : stimulus
    pix_if.valid <= 1'b0;
    pix_if.pixel_word <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.addr <= REG_WIDTH;
    cfg_if.wdata <= '0;
    rst_n <= 1'b0;
    idle_on = 1'b1;
    smooth_level = 8'h80;

    // A few pixels in the reset geometry, then the minimum frame. The sample
    // byte is zero throughout that frame, so its single blur is plain black.
    directed_rows = '{
      '{ROW_PIX, '0, 32'hFFFF_FFFF, 8'd1, 1'b0, '0},
      '{ROW_PIX, '0, 32'h0000_0000, 8'd1, 1'b0, '0},
      '{ROW_PIX, '0, 32'h5A5A_A5A5, 8'd1, 1'b0, '0},
      '{ROW_CFG, REG_SPARE_A, 32'h0000_07FF, 8'd1, 1'b0, '0},
      '{ROW_CFG, REG_WIDTH, 32'd4, 8'd1, 1'b0, '0},
      '{ROW_CFG, REG_HEIGHT, 32'd0, 8'd1, 1'b0, '0},
      '{ROW_PIX, '0, 32'hFFFF_00FF, 8'd12, 1'b0, '0},
      '{ROW_PIX, '0, 32'hA5C3_003C, 8'd12, 1'b0, '0},
      '{ROW_PIX, '0, 32'h0000_0000, 8'd1, 1'b1,
        '{{24'h0, ALPHA_BYTE}, 10'd0, 10'd0, 1'b1}}
    };

    // Random frames: minimum and clamped maximum sizes, partial frames,
    // long output stalls and spare register writes in mid-frame.
    phases = '{
      '{11'd5, 11'd5, 16'd75, 1'b1, 1'b0, 1'b0},
      '{11'd7, 11'd6, 16'd168, 1'b1, 1'b1, 1'b1},
      '{11'd2047, 11'd5, 16'd100, 1'b1, 1'b0, 1'b0},
      '{11'd12, 11'd2047, 16'd180, 1'b1, 1'b0, 1'b0},
      '{11'd10, 11'd8, 16'd160, 1'b0, 1'b0, 1'b0},
      '{11'd16, 11'd11, 16'd216, 1'b1, 1'b1, 1'b1},
      '{11'd6, 11'd9, 16'd108, 1'b1, 1'b0, 1'b0},
      '{11'd8, 11'd7, 16'd112, 1'b0, 1'b0, 1'b0}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].addr, directed_rows[i].data[CFG_DATA_W-1:0]);
      end else begin
        for (int n = 0; n < directed_rows[i].count; n++)
          send_pixel(directed_rows[i].data,
                     directed_rows[i].pinned && (n == directed_rows[i].count - 1),
                     directed_rows[i].pin_result);
      end
    end

    // Random frames, phase by phase; the register writes restart each frame.
    foreach (phases[p]) begin
      wait_idle();
      idle_on = phases[p].idle_on;
      write_reg(REG_WIDTH, phases[p].width);
      write_reg(REG_HEIGHT, phases[p].height);
      setting_count++;
      if (phases[p].hold) hold_request = 1'b1;
      for (int n = 0; n < phases[p].pixels; n++) begin
        if (phases[p].spare_write && n == phases[p].pixels / 3) begin
          wait_idle();
          write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
        end
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    wait_idle();
    $display("Sent %0d pixels over %0d random frame geometries; %0d blurs checked.",
             pixel_count, setting_count, result_count);
    $display("Clamped sizes, frame restarts, spare writes and %0d frame ends seen.",
             frame_count);
    if (mismatch_count == 0 && pending_blurs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
sv/gbw_pkg.sv
sv/gbw_pix_if.sv
sv/gbw_res_if.sv
sv/gbw_cfg_if.sv
sv/gbw_line_buf.sv
sv/gbw_cell.sv
sv/gaussian_blur_window_filter.sv
bench/gaussian_blur_window_filter_test.sv
